### hdl/pfod_pkg.sv
// Package for the pulse frame obstacle decoder.
// Holds frame constants, register indexes and the threshold bundle type.
// No dependencies.
`timescale 1ns / 1ps

package pfod_pkg;

    localparam int FRAME_EDGES = 34;
    localparam int POS_W       = 6;

    localparam logic [15:0] SYNC_MIN = 16'd1790;
    localparam logic [15:0] SYNC_MAX = 16'd1800;
    localparam logic [2:0]  ZONE_MAX = 3'd5;

    localparam logic [POS_W-1:0] POS_FIRST = 6'd0;
    localparam logic [POS_W-1:0] POS_SYNC  = 6'd1;
    localparam logic [POS_W-1:0] POS_LAST  = 6'(FRAME_EDGES - 1);

    localparam logic [2:0] REG_THRESH_STOP      = 3'd0;
    localparam logic [2:0] REG_THRESH_HALF      = 3'd1;
    localparam logic [2:0] REG_THRESH_ONE       = 3'd2;
    localparam logic [2:0] REG_THRESH_ONE_HALF  = 3'd3;
    localparam logic [2:0] REG_THRESH_TWO       = 3'd4;
    localparam logic [2:0] REG_THRESH_OPEN      = 3'd5;
    localparam logic [2:0] REG_BIT_ONE_LIMIT    = 3'd6;
    localparam logic [2:0] REG_CLAMP_FLOOR      = 3'd7;

    typedef struct packed {
        logic [7:0] stop;
        logic [7:0] half_metre;
        logic [7:0] one_metre;
        logic [7:0] one_half_metre;
        logic [7:0] two_metre;
        logic [7:0] open;
        logic [7:0] clamp_floor;
    } grade_cfg_t;

endpackage

### hdl/pfod_grade.sv
// Clamp one decoded reading byte and grade it into a distance zone.
// Depends on pfod_pkg for the threshold bundle.
`timescale 1ns / 1ps

module pfod_grade (
    input  pfod_pkg::grade_cfg_t cfg,
    input  logic [7:0]           raw,
    input  logic [2:0]           held_zone,
    output logic [7:0]           reading,
    output logic [2:0]           zone
);
    import pfod_pkg::*;

    always_comb begin
        if (raw != 8'd0 && raw < cfg.clamp_floor) begin
            reading = 8'hFF;
        end else begin
            reading = raw;
        end
    end

    always_comb begin
        if (reading >= cfg.stop) begin
            zone = ZONE_MAX;
        end else if (reading > cfg.half_metre) begin
            zone = 3'd4;
        end else if (reading > cfg.one_metre) begin
            zone = 3'd3;
        end else if (reading > cfg.one_half_metre) begin
            zone = 3'd2;
        end else if (reading > cfg.two_metre) begin
            zone = 3'd1;
        end else if (reading > cfg.open) begin
            zone = 3'd0;
        end else begin
            zone = held_zone;
        end
    end

endmodule

### hdl/pulse_frame_obstacle_decoder_top.sv
// Top level of the pulse frame obstacle decoder: config registers, frame
// sequencing and output register. Depends on pfod_pkg and pfod_grade.
//
// Usage:
//   The s_ channel carries one 16-bit timer capture per sensor edge. Each
//   capture is taken into an input register and decoded from there
//   against the previous capture. Frame positions run 0 to 33; the
//   sync interval at position 1 must lie in 1790..1800. A result transfer
//   on the m_ channel follows the last edge of a frame (readings and zones)
//   or a bad sync interval (m_tuser high, readings zero, held zones).
//   Path: a capture is held in the input register and decoded, and its result
//   is loaded into the output register, which presents it on the m_ channel.
//   Throughput: one capture per cycle unless a result waits on m_tready,
//   set by the single decode step between the input and output registers.
//   Stall: while m_tready is low a result waits in the output register;
//   captures that produce no result keep advancing, and one that produces a
//   result waits in the input register, dropping s_tready.
//   Reset: aresetn low clears the frame position, previous capture, shifter
//   and held zones to zero and loads the register defaults.
//   Configuration: APB, register i at byte address 4*i. The user must write
//   it only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module pulse_frame_obstacle_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    // capture_time [15:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // front_reading [7:0], back_reading [15:8], front_zone [18:16],
    // back_zone [21:19], zero fill [23:22]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    // sync_error [0]
    output logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pfod_pkg::*;

    logic [7:0]  thr_stop_reg, thr_half_reg, thr_one_reg;
    logic [7:0]  thr_one_half_reg, thr_two_reg, thr_open_reg;
    logic [15:0] bit_limit_reg;
    logic [7:0]  clamp_floor_reg;

    logic        in_valid_reg;
    logic [15:0] cap_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      prev_reg;
    logic [15:0]      shift_reg, shift_next;
    logic [2:0]       held_front_reg, held_back_reg;

    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic        out_user_reg;

    logic [POS_W-1:0] pos_cur;
    logic [15:0]      interval;
    logic             sync_bad;
    logic             produces;
    logic             is_last;
    logic             advance;
    logic             cfg_write;

    grade_cfg_t  gcfg;
    logic [7:0]  front_reading, back_reading;
    logic [2:0]  front_zone, back_zone;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_stop_reg     <= 8'd255;
            thr_half_reg     <= 8'd250;
            thr_one_reg      <= 8'd245;
            thr_one_half_reg <= 8'd240;
            thr_two_reg      <= 8'd235;
            thr_open_reg     <= 8'd0;
            bit_limit_reg    <= 16'd400;
            clamp_floor_reg  <= 8'd229;
        end else if (cfg_write) begin
            case (paddr[4:2])
                REG_THRESH_STOP:     thr_stop_reg     <= pwdata[7:0];
                REG_THRESH_HALF:     thr_half_reg     <= pwdata[7:0];
                REG_THRESH_ONE:      thr_one_reg      <= pwdata[7:0];
                REG_THRESH_ONE_HALF: thr_one_half_reg <= pwdata[7:0];
                REG_THRESH_TWO:      thr_two_reg      <= pwdata[7:0];
                REG_THRESH_OPEN:     thr_open_reg     <= pwdata[7:0];
                REG_BIT_ONE_LIMIT:   bit_limit_reg    <= pwdata[15:0];
                REG_CLAMP_FLOOR:     clamp_floor_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_THRESH_STOP:     prdata = {24'd0, thr_stop_reg};
            REG_THRESH_HALF:     prdata = {24'd0, thr_half_reg};
            REG_THRESH_ONE:      prdata = {24'd0, thr_one_reg};
            REG_THRESH_ONE_HALF: prdata = {24'd0, thr_one_half_reg};
            REG_THRESH_TWO:      prdata = {24'd0, thr_two_reg};
            REG_THRESH_OPEN:     prdata = {24'd0, thr_open_reg};
            REG_BIT_ONE_LIMIT:   prdata = {16'd0, bit_limit_reg};
            REG_CLAMP_FLOOR:     prdata = {24'd0, clamp_floor_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // decode step on the registered capture
    always_comb begin
        if (prev_reg < cap_reg) begin
            interval = cap_reg - prev_reg;
        end else begin
            interval = cap_reg - prev_reg - 16'd1;
        end
        pos_cur  = (pos_reg > POS_LAST) ? POS_FIRST : pos_reg;
        sync_bad = (interval < SYNC_MIN) || (interval > SYNC_MAX);
        is_last  = (pos_cur == POS_LAST);
        produces = ((pos_cur == POS_SYNC) && sync_bad) || is_last;

        shift_next = shift_reg;
        pos_next   = pos_cur + 6'd1;
        if (pos_cur == POS_FIRST) begin
            shift_next = 16'd0;
        end else if (pos_cur == POS_SYNC) begin
            if (sync_bad) begin
                pos_next = POS_FIRST;
            end
        end else begin
            if (pos_cur[0]) begin
                shift_next = {shift_reg[14:0], interval < bit_limit_reg};
            end
            if (is_last) begin
                pos_next = POS_FIRST;
            end
        end
    end

    assign gcfg = '{stop: thr_stop_reg, half_metre: thr_half_reg,
                    one_metre: thr_one_reg, one_half_metre: thr_one_half_reg,
                    two_metre: thr_two_reg, open: thr_open_reg,
                    clamp_floor: clamp_floor_reg};

    pfod_grade u_grade_front (
        .cfg       (gcfg),
        .raw       (shift_next[15:8]),
        .held_zone (held_front_reg),
        .reading   (front_reading),
        .zone      (front_zone)
    );

    pfod_grade u_grade_back (
        .cfg       (gcfg),
        .raw       (shift_next[7:0]),
        .held_zone (held_back_reg),
        .reading   (back_reading),
        .zone      (back_zone)
    );

    assign advance  = in_valid_reg && (!produces || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            pos_reg        <= POS_FIRST;
            prev_reg       <= 16'd0;
            shift_reg      <= 16'd0;
            held_front_reg <= 3'd0;
            held_back_reg  <= 3'd0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                pos_reg   <= pos_next;
                prev_reg  <= cap_reg;
                shift_reg <= shift_next;
                if (is_last) begin
                    held_front_reg <= front_zone;
                    held_back_reg  <= back_zone;
                end
            end
            if (advance && produces) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cap_reg <= s_tdata;
        end
        if (advance && produces) begin
            if (is_last) begin
                out_data_reg <= {2'b00, back_zone, front_zone, back_reading, front_reading};
                out_user_reg <= 1'b0;
            end else begin
                out_data_reg <= {2'b00, held_back_reg, held_front_reg, 16'd0};
                out_user_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_LAST)
        else $error("frame position past last edge");

    a_sync_err_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[15:0] == 16'd0))
        else $error("sync error result carries nonzero readings");

    a_zone_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[18:16] <= ZONE_MAX && m_tdata[21:19] <= ZONE_MAX))
        else $error("zone out of range");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && produces) |=> (pos_reg == POS_FIRST && m_tvalid))
        else $error("frame did not restart after a result");

    a_held_on_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && produces && !is_last) |=>
        (held_front_reg == $past(held_front_reg) && held_back_reg == $past(held_back_reg)))
        else $error("held zones changed on sync error");

endmodule
